@@ sv/rsa_pkg.sv @@
// ----------------------------------------------------------------------------
// rsa_pkg
// Shared codes, field widths and control structs of the request slot
// allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rsa_pkg;

  localparam int unsigned PROC_W   = 16;
  localparam int unsigned ID_W     = 48;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LEVEL_W  = 3;
  localparam int unsigned SLOT_W   = 24;
  localparam int unsigned FREE_W   = 25;
  localparam int unsigned MAXD_W   = 24;
  localparam int unsigned IDLV_W   = 8;

  localparam int unsigned S_DATA_W = 64;
  localparam int unsigned M_DATA_W = 104;

  localparam int unsigned OFF_LEVEL = 48;
  localparam int unsigned OFF_SLOT  = 51;
  localparam int unsigned OFF_INUSE = 75;
  localparam int unsigned OFF_FREE  = 76;
  localparam int unsigned PAD_W     = M_DATA_W - OFF_FREE - FREE_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_QUERY   = 2'd2
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_EXHAUSTED = 2'd1,
    STATUS_BAD       = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    RES_OK_ALLOC   = 3'd0,
    RES_EXHAUST    = 3'd1,
    RES_BAD        = 3'd2,
    RES_REL_OK     = 3'd3,
    RES_REL_UNUSED = 3'd4,
    RES_QUERY      = 3'd5
  } res_kind_t;

  typedef struct packed {
    logic      clr_step;
    logic      load;
    logic      grow;
    logic      start_alloc;
    logic      start_id;
    logic      mem_rd;
    logic      adv;
    logic      commit;
    res_kind_t kind;
  } cmd_t;

  typedef struct packed {
    logic  clr_done;
    mode_t op;
    logic  full;
    logic  can_grow;
    logic  id_ok;
    logic  bit_used;
  } stat_t;

endpackage

`default_nettype wire

@@ sv/request_slot_allocator.sv @@
// ----------------------------------------------------------------------------
// request_slot_allocator
// Next-fit descriptor id allocator over levels of growing size.
// ----------------------------------------------------------------------------
// Channel   Dir  Accept               Contents
// s_*       in   s_tvalid & s_tready  tuser: mode; tdata: proc, request_id
// m_*       out  m_tvalid & m_tready  tuser: status; tdata: id, level, slot,..
// max_desc  in   max_descriptors_we   max_descriptors_wdata
//
// One item in flight. Allocate: the next-fit probe steps past each used slot
// that it finds; release and query probe once; exhausted or bad id skip the probe.
// Each probe is one read of the slot-used memory followed by a check.
// After reset a clearing pass over all BASE_SLOTS*(2**NUM_LEVELS-1) slots
// (240 at the defaults) runs before s_tready rises.
// A stalled result holds in the output register; no new item is taken then
// past the finish step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module request_slot_allocator #(
  parameter int unsigned BASE_SLOTS = 16,
  parameter int unsigned NUM_LEVELS = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // [15:0] proc, [63:16] request_id
  input  wire logic [rsa_pkg::S_DATA_W-1:0]  s_tdata,
  // [1:0] mode
  input  wire logic [rsa_pkg::MODE_W-1:0]    s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // [47:0] issued_id, [50:48] level, [74:51] slot, [75] in_use,
  // [100:76] free_at_level, [103:101] zero
  output logic      [rsa_pkg::M_DATA_W-1:0]  m_tdata,
  // [1:0] status
  output logic      [rsa_pkg::STATUS_W-1:0]  m_tuser,
  input  wire logic                          max_descriptors_we,
  input  wire logic [rsa_pkg::MAXD_W-1:0]    max_descriptors_wdata
);

  rsa_pkg::cmd_t  cmd;
  rsa_pkg::stat_t stat;

  rsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rsa_datapath #(
    .BASE_SLOTS (BASE_SLOTS),
    .NUM_LEVELS (NUM_LEVELS)
  ) u_datapath (
    .clk                   (clk),
    .rst                   (rst),
    .s_tdata               (s_tdata),
    .s_tuser               (s_tuser),
    .max_descriptors_we    (max_descriptors_we),
    .max_descriptors_wdata (max_descriptors_wdata),
    .cmd                   (cmd),
    .stat                  (stat),
    .m_tdata               (m_tdata),
    .m_tuser               (m_tuser)
  );

endmodule

`default_nettype wire

@@ sv/rsa_ctrl.sv @@
// ----------------------------------------------------------------------------
// rsa_ctrl
// Sequencer of the allocator: clearing pass, decode, slot probe and
// result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  input  wire rsa_pkg::stat_t stat,
  output rsa_pkg::cmd_t      cmd
);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_PREP   = 6'b000100,
    S_READ   = 6'b001000,
    S_CHECK  = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t              state;
  state_t              state_next;
  rsa_pkg::res_kind_t  kind;
  rsa_pkg::res_kind_t  kind_next;
  logic                out_valid;
  logic                can_load;

  assign can_load = !out_valid || m_tready;
  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;

  always_comb begin
    cmd        = '0;
    state_next = state;
    kind_next  = kind;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        case (stat.op) inside
          rsa_pkg::MODE_ALLOC: begin
            if (stat.full && !stat.can_grow) begin
              kind_next  = rsa_pkg::RES_EXHAUST;
              state_next = S_FINISH;
            end else begin
              cmd.grow        = stat.full;
              cmd.start_alloc = 1'b1;
              state_next      = S_READ;
            end
          end
          rsa_pkg::MODE_RELEASE, rsa_pkg::MODE_QUERY: begin
            if (stat.id_ok) begin
              cmd.start_id = 1'b1;
              state_next   = S_READ;
            end else begin
              kind_next  = rsa_pkg::RES_BAD;
              state_next = S_FINISH;
            end
          end
          default: begin
            kind_next  = rsa_pkg::RES_BAD;
            state_next = S_FINISH;
          end
        endcase
      end
      S_READ: begin
        cmd.mem_rd = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        state_next = S_FINISH;
        case (stat.op)
          rsa_pkg::MODE_ALLOC: begin
            if (stat.bit_used) begin
              cmd.adv    = 1'b1;
              state_next = S_READ;
            end else begin
              kind_next = rsa_pkg::RES_OK_ALLOC;
            end
          end
          rsa_pkg::MODE_RELEASE: begin
            kind_next = stat.bit_used ? rsa_pkg::RES_REL_OK : rsa_pkg::RES_REL_UNUSED;
          end
          rsa_pkg::MODE_QUERY: begin
            kind_next = rsa_pkg::RES_QUERY;
          end
          default: begin
            kind_next = rsa_pkg::RES_BAD;
          end
        endcase
      end
      S_FINISH: begin
        if (can_load) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
    cmd.kind = kind;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      kind      <= rsa_pkg::RES_BAD;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      kind  <= kind_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/rsa_datapath.sv @@
// ----------------------------------------------------------------------------
// rsa_datapath
// Slot-used memory, level bookkeeping, id decode and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsa_datapath #(
  parameter int unsigned BASE_SLOTS = 16,
  parameter int unsigned NUM_LEVELS = 4
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [rsa_pkg::S_DATA_W-1:0]   s_tdata,
  input  wire logic [rsa_pkg::MODE_W-1:0]     s_tuser,
  input  wire logic                           max_descriptors_we,
  input  wire logic [rsa_pkg::MAXD_W-1:0]     max_descriptors_wdata,
  input  wire rsa_pkg::cmd_t                  cmd,
  output rsa_pkg::stat_t                      stat,
  output logic      [rsa_pkg::M_DATA_W-1:0]   m_tdata,
  output logic      [rsa_pkg::STATUS_W-1:0]   m_tuser
);

  localparam int unsigned SLOT_TOTAL = BASE_SLOTS * ((2 ** NUM_LEVELS) - 1);
  localparam int unsigned ADDR_W     = (SLOT_TOTAL > 1) ? $clog2(SLOT_TOTAL) : 1;
  localparam int unsigned SIZE_W     = $clog2(BASE_SLOTS) + NUM_LEVELS;
  localparam int unsigned LVL_W      = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int unsigned CMP_W      = (SIZE_W > rsa_pkg::MAXD_W) ? SIZE_W : rsa_pkg::MAXD_W;

  logic                               used_mem [SLOT_TOTAL];
  logic                               rd_bit;
  logic [ADDR_W-1:0]                  clr_addr;

  logic [rsa_pkg::MAXD_W-1:0]         max_descriptors;
  logic [LVL_W-1:0]                   active_level;
  logic [SIZE_W-1:0]                  active_free;
  logic [SIZE_W-1:0]                  free_next;
  logic [SIZE_W-1:0]                  next_slot;

  rsa_pkg::mode_t                     mode_q;
  logic [rsa_pkg::PROC_W-1:0]         proc_q;
  logic [rsa_pkg::IDLV_W-1:0]         id_level;
  logic [rsa_pkg::SLOT_W-1:0]         id_plus1;

  logic [LVL_W-1:0]                   acc_lv;
  logic [SIZE_W-1:0]                  acc_slot;
  logic [SIZE_W-1:0]                  acc_size;
  logic [ADDR_W-1:0]                  acc_addr;

  logic [SIZE_W-1:0]                  grow_size;
  logic [rsa_pkg::SLOT_W-1:0]         dec_size;
  logic [rsa_pkg::SLOT_W-1:0]         dec_slot;

  logic                               mem_we;
  logic [ADDR_W-1:0]                  mem_addr;

  logic [rsa_pkg::STATUS_W-1:0]       o_status;
  logic [rsa_pkg::ID_W-1:0]           o_issued;
  logic [rsa_pkg::LEVEL_W-1:0]        o_level;
  logic [rsa_pkg::SLOT_W-1:0]         o_slot;
  logic                               o_inuse;

  logic [rsa_pkg::STATUS_W-1:0]       status_q;
  logic [rsa_pkg::ID_W-1:0]           issued_q;
  logic [rsa_pkg::LEVEL_W-1:0]        level_q;
  logic [rsa_pkg::SLOT_W-1:0]         slot_q;
  logic                               inuse_q;
  logic [rsa_pkg::FREE_W-1:0]         free_q;

  assign grow_size = SIZE_W'(BASE_SLOTS) << (active_level + LVL_W'(1));
  assign dec_size  = rsa_pkg::SLOT_W'(BASE_SLOTS) << id_level[2:0];
  assign dec_slot  = id_plus1 - rsa_pkg::SLOT_W'(1);
  assign acc_size  = SIZE_W'(BASE_SLOTS) << acc_lv;
  assign acc_addr  = (ADDR_W'(BASE_SLOTS) << acc_lv) - ADDR_W'(BASE_SLOTS) + ADDR_W'(acc_slot);

  always_comb begin
    stat.clr_done = (clr_addr == ADDR_W'(SLOT_TOTAL - 1));
    stat.op       = mode_q;
    stat.full     = (active_free == '0);
    stat.can_grow = (active_level != LVL_W'(NUM_LEVELS - 1)) &&
                    !((max_descriptors != '0) &&
                      (CMP_W'(grow_size) > CMP_W'(max_descriptors)));
    stat.id_ok    = (id_level < rsa_pkg::IDLV_W'(NUM_LEVELS)) && (id_plus1 != '0) &&
                    (dec_slot < dec_size);
    stat.bit_used = rd_bit;
  end

  assign mem_we   = cmd.clr_step ||
                    (cmd.commit && ((cmd.kind == rsa_pkg::RES_OK_ALLOC) ||
                                    (cmd.kind == rsa_pkg::RES_REL_OK)));
  assign mem_addr = cmd.clr_step ? clr_addr : acc_addr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      used_mem[mem_addr] <= !cmd.clr_step && (cmd.kind == rsa_pkg::RES_OK_ALLOC);
    end
    if (cmd.mem_rd) begin
      rd_bit <= used_mem[acc_addr];
    end
  end

  always_comb begin
    free_next = active_free;
    if (cmd.kind == rsa_pkg::RES_OK_ALLOC) begin
      free_next = active_free - SIZE_W'(1);
    end else if ((cmd.kind == rsa_pkg::RES_REL_OK) && (acc_lv == active_level)) begin
      free_next = active_free + SIZE_W'(1);
    end
  end

  always_comb begin
    o_status = rsa_pkg::STATUS_BAD;
    o_issued = '0;
    o_level  = '0;
    o_slot   = '0;
    o_inuse  = 1'b0;
    case (cmd.kind)
      rsa_pkg::RES_OK_ALLOC: begin
        o_status = rsa_pkg::STATUS_OK;
        o_issued = {proc_q, rsa_pkg::IDLV_W'(acc_lv),
                    rsa_pkg::SLOT_W'(acc_slot) + rsa_pkg::SLOT_W'(1)};
        o_level  = rsa_pkg::LEVEL_W'(acc_lv);
        o_slot   = rsa_pkg::SLOT_W'(acc_slot);
      end
      rsa_pkg::RES_EXHAUST: begin
        o_status = rsa_pkg::STATUS_EXHAUSTED;
        o_level  = rsa_pkg::LEVEL_W'(active_level);
      end
      rsa_pkg::RES_REL_OK: begin
        o_status = rsa_pkg::STATUS_OK;
        o_level  = rsa_pkg::LEVEL_W'(acc_lv);
        o_slot   = rsa_pkg::SLOT_W'(acc_slot);
      end
      rsa_pkg::RES_REL_UNUSED: begin
        o_level = rsa_pkg::LEVEL_W'(acc_lv);
        o_slot  = rsa_pkg::SLOT_W'(acc_slot);
      end
      rsa_pkg::RES_QUERY: begin
        o_status = rsa_pkg::STATUS_OK;
        o_level  = rsa_pkg::LEVEL_W'(acc_lv);
        o_slot   = rsa_pkg::SLOT_W'(acc_slot);
        o_inuse  = rd_bit;
      end
      default: begin
        o_status = rsa_pkg::STATUS_BAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr        <= '0;
      max_descriptors <= '0;
      active_level    <= '0;
      active_free     <= SIZE_W'(BASE_SLOTS);
      next_slot       <= '0;
    end else begin
      if (cmd.clr_step && !stat.clr_done) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (max_descriptors_we) begin
        max_descriptors <= max_descriptors_wdata;
      end
      if (cmd.grow) begin
        active_level <= active_level + LVL_W'(1);
        active_free  <= grow_size;
        next_slot    <= '0;
      end
      if (cmd.commit) begin
        active_free <= free_next;
        if (cmd.kind == rsa_pkg::RES_OK_ALLOC) begin
          next_slot <= acc_slot;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q   <= rsa_pkg::mode_t'(s_tuser);
      proc_q   <= s_tdata[rsa_pkg::PROC_W-1:0];
      id_plus1 <= s_tdata[rsa_pkg::PROC_W +: rsa_pkg::SLOT_W];
      id_level <= s_tdata[rsa_pkg::PROC_W + rsa_pkg::SLOT_W +: rsa_pkg::IDLV_W];
    end
    if (cmd.start_alloc) begin
      acc_lv   <= cmd.grow ? (active_level + LVL_W'(1)) : active_level;
      acc_slot <= cmd.grow ? '0 : next_slot;
    end else if (cmd.start_id) begin
      acc_lv   <= id_level[LVL_W-1:0];
      acc_slot <= dec_slot[SIZE_W-1:0];
    end else if (cmd.adv) begin
      acc_slot <= (acc_slot == acc_size - SIZE_W'(1)) ? '0 : acc_slot + SIZE_W'(1);
    end
    if (cmd.commit) begin
      status_q <= o_status;
      issued_q <= o_issued;
      level_q  <= o_level;
      slot_q   <= o_slot;
      inuse_q  <= o_inuse;
      free_q   <= rsa_pkg::FREE_W'(free_next);
    end
  end

  assign m_tdata = {{rsa_pkg::PAD_W{1'b0}}, free_q, inuse_q, slot_q, level_q, issued_q};
  assign m_tuser = status_q;

endmodule

`default_nettype wire

@@ sv/rsa_checker.sv @@
// ----------------------------------------------------------------------------
// rsa_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsa_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_tvalid,
  input wire logic                          s_tready,
  input wire logic                          m_tvalid,
  input wire logic [rsa_pkg::M_DATA_W-1:0]  m_tdata,
  input wire logic [rsa_pkg::STATUS_W-1:0]  m_tuser
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second item taken while one is in work");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tuser == rsa_pkg::STATUS_OK) ||
                  (m_tuser == rsa_pkg::STATUS_EXHAUSTED) ||
                  (m_tuser == rsa_pkg::STATUS_BAD)))
    else $error("undefined status code");

  a_exhaust_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == rsa_pkg::STATUS_EXHAUSTED)) |->
      ((m_tdata[rsa_pkg::ID_W-1:0] == '0) &&
       (m_tdata[rsa_pkg::OFF_SLOT +: rsa_pkg::SLOT_W] == '0) &&
       !m_tdata[rsa_pkg::OFF_INUSE]))
    else $error("exhausted result carries an id or slot");

  a_issued_form: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == rsa_pkg::STATUS_OK) && (m_tdata[rsa_pkg::ID_W-1:0] != '0)) |->
      ((m_tdata[rsa_pkg::SLOT_W-1:0] != '0) && !m_tdata[rsa_pkg::OFF_INUSE] &&
       (m_tdata[rsa_pkg::SLOT_W-1:0] ==
        m_tdata[rsa_pkg::OFF_SLOT +: rsa_pkg::SLOT_W] + rsa_pkg::SLOT_W'(1))))
    else $error("issued id does not match reported slot");

endmodule

bind request_slot_allocator rsa_checker u_rsa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
